[hw/rtl/srq_pkg.sv]
// ----------------------------------------------------------------------------
// srq_pkg
// shared types and constants of the sorted ready queue
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 16;
    localparam int KEY_WIDTH    = 32;
    localparam int IDX_WIDTH    = $clog2(DEPTH);
    localparam int CNT_WIDTH    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND      = 2'd0,
        OP_SORTED      = 2'd1,
        OP_DEQUEUE     = 2'd2,
        OP_FIND_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INS_RD,
        S_INS_WR,
        S_PLACE,
        S_REM_RD,
        S_REM_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [HANDLE_WIDTH-1:0]     handle;
        logic signed [KEY_WIDTH-1:0] key;
    } entry_t;

    // access group from the sequencer to the entry store
    typedef struct packed {
        logic                 we;
        logic [IDX_WIDTH-1:0] waddr;
        entry_t               wdata;
        logic [IDX_WIDTH-1:0] raddr;
    } mem_req_t;

endpackage

[hw/rtl/srq_store.sv]
// ----------------------------------------------------------------------------
// srq_store
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module srq_store
    import srq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

[hw/rtl/srq_cmp.sv]
// ----------------------------------------------------------------------------
// srq_cmp
// shared compare unit: decides whether a stored entry stops the scan
// ----------------------------------------------------------------------------
module srq_cmp
    import srq_pkg::*;
(
    input  op_t                         op,
    input  entry_t                      entry,
    input  logic [HANDLE_WIDTH-1:0]     req_handle,
    input  logic signed [KEY_WIDTH-1:0] req_key,
    output logic                        hit
);

    always_comb
    begin
        case (op)
            // first entry whose key is not below the new key
            OP_SORTED:      hit = (entry.key >= req_key);
            OP_FIND_REMOVE: hit = (entry.handle == req_handle);
            OP_DEQUEUE:     hit = 1'b1;
            default:        hit = 1'b0;
        endcase
    end

endmodule

[hw/rtl/sorted_ready_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_ready_queue_core
// ordered ready queue of task handles with signed keys, sequenced over one
// entry memory and one shared compare unit
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on status, handle_out,
// is_empty and count for exactly one cycle, marked by done, and must be taken
// in that cycle since the block cannot be stalled. Entries live in a single
// memory with one read and one write port, so the work depends on queue
// contents: an append writes the entry at the tail; a sorted insert reads and
// compares entries from the head up to the first key not below its own, or the
// tail, then moves each entry behind that point one slot toward the tail and
// writes the new entry into the gap; a dequeue takes the head and a find-remove
// scans for the first matching handle, and both then move each entry behind it
// one slot toward the head. An insert into a full queue is dropped with status
// full, and a request with nothing to remove answers with a miss. The slowest
// request is a sorted insert that does not land at the tail.
// ----------------------------------------------------------------------------
module sorted_ready_queue_core
    import srq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [HANDLE_WIDTH-1:0]     handle,
    input  logic signed [KEY_WIDTH-1:0] key,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [HANDLE_WIDTH-1:0]     handle_out,
    output logic                        is_empty,
    output logic [CNT_WIDTH-1:0]        count
);

    // control state
    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [CNT_WIDTH-1:0]   idx_reg, idx_next;   // scan position
    logic [CNT_WIDTH-1:0]   ptr_reg, ptr_next;   // shift position

    // request payload and result
    op_t                         op_reg, op_next;
    logic [HANDLE_WIDTH-1:0]     hnd_reg, hnd_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic [IDX_WIDTH-1:0]        pos_reg, pos_next;
    status_t                     status_reg, status_next;
    logic [HANDLE_WIDTH-1:0]     hout_reg, hout_next;

    mem_req_t             mem_req;
    entry_t               rd_data;
    logic                 hit;
    logic [CNT_WIDTH-1:0] ptr_dec;
    logic [CNT_WIDTH-1:0] ptr_inc;

    srq_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    srq_cmp u_cmp
    (
        .op         (op_reg),
        .entry      (rd_data),
        .req_handle (hnd_reg),
        .req_key    (key_reg),
        .hit        (hit)
    );

    assign ptr_dec = ptr_reg - 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hnd_reg    <= hnd_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
    end

    // sequencer: scan with the compare unit, then shift entries one at a time, a read step then a write step each
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        op_next     = op_reg;
        hnd_next    = hnd_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        hout_next   = hout_reg;

        mem_req       = '0;
        mem_req.raddr = idx_reg[IDX_WIDTH-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_t'(opcode);
                    hnd_next    = handle;
                    key_next    = key;
                    idx_next    = '0;
                    hout_next   = '0;
                    status_next = ST_OK;
                    if ((opcode inside {OP_APPEND, OP_SORTED}) &&
                        (cnt_reg == CNT_WIDTH'(DEPTH)))
                    begin
                        // full: request dropped
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else if (opcode == OP_APPEND)
                    begin
                        pos_next   = cnt_reg[IDX_WIDTH-1:0];
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // scan ran off the tail
                    if (op_reg == OP_SORTED)
                    begin
                        pos_next   = cnt_reg[IDX_WIDTH-1:0];
                        ptr_next   = cnt_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    mem_req.raddr = idx_reg[IDX_WIDTH-1:0];
                    state_next    = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    pos_next = idx_reg[IDX_WIDTH-1:0];
                    if (op_reg == OP_SORTED)
                    begin
                        ptr_next   = cnt_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        hout_next  = rd_data.handle;
                        ptr_next   = idx_reg;
                        state_next = S_REM_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            // open a slot at the insert point, moving entries toward the tail
            S_INS_RD:
            begin
                if (ptr_reg == CNT_WIDTH'(pos_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mem_req.raddr = ptr_dec[IDX_WIDTH-1:0];
                    state_next    = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[IDX_WIDTH-1:0];
                mem_req.wdata = rd_data;
                ptr_next      = ptr_dec;
                state_next    = S_INS_RD;
            end

            S_PLACE:
            begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = pos_reg;
                mem_req.wdata.handle = hnd_reg;
                mem_req.wdata.key    = key_reg;
                cnt_next             = cnt_reg + 1'b1;
                state_next           = S_RESP;
            end

            // close the gap, moving entries toward the head
            S_REM_RD:
            begin
                if (ptr_inc >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_req.raddr = ptr_inc[IDX_WIDTH-1:0];
                    state_next    = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[IDX_WIDTH-1:0];
                mem_req.wdata = rd_data;
                ptr_next      = ptr_inc;
                state_next    = S_REM_RD;
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result ports
    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RESP);
    assign status     = status_reg;
    assign handle_out = hout_reg;
    assign is_empty   = (cnt_reg == '0);
    assign count      = cnt_reg;

endmodule

[hw/rtl/srq_checker.sv]
// ----------------------------------------------------------------------------
// srq_checker
// port-level checks of the sorted ready queue, bound to the top level
// ----------------------------------------------------------------------------
module srq_checker
    import srq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic [1:0]              status,
    input logic [HANDLE_WIDTH-1:0] handle_out,
    input logic                    is_empty,
    input logic [CNT_WIDTH-1:0]    count
);

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a result closes the request and frees the block
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy ##1 !busy))
        else $error("result shown outside a busy request or block stays busy");

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    // a dropped insert only happens when full
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count == CNT_WIDTH'(DEPTH)))
        else $error("insert dropped while not full");

    // a failed request (full or miss) shows a zero handle_out
    a_fail_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (handle_out == '0))
        else $error("nonzero handle on failed request");

endmodule

bind sorted_ready_queue_core srq_checker u_srq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .handle_out (handle_out),
    .is_empty   (is_empty),
    .count      (count)
);

[tb/tb_sorted_ready_queue_core.sv]
// ----------------------------------------------------------------------------
// tb_sorted_ready_queue_core
// self-checking testbench of the sorted ready queue core
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty and full corners, key
// and handle extremes, equal keys and a failed search. A long random part
// follows. It mostly fills and drains the queue with random content, and mixes
// in plain noise requests. Every accepted request runs through a
// shadow queue. The shadow queue yields the expected result, unless a typed row
// brings its own; the expected result is then compared field by field with the
// next done strobe. The sender idles at several rates over the run.
// ----------------------------------------------------------------------------
module tb_sorted_ready_queue_core;
    import srq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1225;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;   // a bit over the worst latency
    localparam int CYCLE_LIMIT  = 400000;

    // one result as the block reports it
    typedef struct packed {
        status_t                 status;
        logic [HANDLE_WIDTH-1:0] handle_out;
        logic                    is_empty;
        logic [CNT_WIDTH-1:0]    count;
    } queue_result_t;

    // one request, with an optional hand-written expected result
    typedef struct {
        op_t                         op;
        logic [HANDLE_WIDTH-1:0]     h;
        logic signed [KEY_WIDTH-1:0] k;
        bit                          typed;
        queue_result_t               res;
    } request_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  opcode;
    logic [HANDLE_WIDTH-1:0]     handle;
    logic signed [KEY_WIDTH-1:0] key;
    logic                        done;
    logic [1:0]                  status;
    logic [HANDLE_WIDTH-1:0]     handle_out;
    logic                        is_empty;
    logic [CNT_WIDTH-1:0]        count;

    // shadow copy of the queue contents, entry 0 is the head
    logic [HANDLE_WIDTH-1:0]     shadow_handle [DEPTH];
    logic signed [KEY_WIDTH-1:0] shadow_key [DEPTH];
    int                          shadow_cnt;

    queue_result_t pending_results [$];
    request_t      directed_rows [$];

    // the request on the ports, read back by the monitor when accepted
    bit            cur_typed;
    queue_result_t cur_res;

    int            err_cnt;
    int            cycle_cnt;
    queue_result_t got_res;
    queue_result_t want_res;
    queue_result_t shadow_res;

    sorted_ready_queue_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .handle     (handle),
        .key        (key),
        .done       (done),
        .status     (status),
        .handle_out (handle_out),
        .is_empty   (is_empty),
        .count      (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // apply one request to the shadow queue and return what the block should say
    function automatic queue_result_t apply_queue_op(op_t op, logic [HANDLE_WIDTH-1:0] h,
                                                     logic signed [KEY_WIDTH-1:0] k);
        queue_result_t r;
        int            pos;
        int            i;
        r.status     = ST_OK;
        r.handle_out = '0;
        case (op)
            OP_APPEND, OP_SORTED:
            begin
                if (shadow_cnt >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = shadow_cnt;
                    if (op == OP_SORTED)
                    begin
                        // goes ahead of the first entry with a key not below its own
                        pos = 0;
                        while (pos < shadow_cnt && shadow_key[pos] < k)
                            pos++;
                    end
                    for (i = shadow_cnt; i > pos; i--)
                    begin
                        shadow_handle[i] = shadow_handle[i-1];
                        shadow_key[i]    = shadow_key[i-1];
                    end
                    shadow_handle[pos] = h;
                    shadow_key[pos]    = k;
                    shadow_cnt++;
                end
            end
            default:
            begin
                // dequeue takes the head, find-remove the first matching handle
                pos = 0;
                if (op == OP_FIND_REMOVE)
                begin
                    while (pos < shadow_cnt && shadow_handle[pos] != h)
                        pos++;
                end
                if (pos >= shadow_cnt)
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    r.handle_out = shadow_handle[pos];
                    for (i = pos; i + 1 < shadow_cnt; i++)
                    begin
                        shadow_handle[i] = shadow_handle[i+1];
                        shadow_key[i]    = shadow_key[i+1];
                    end
                    shadow_cnt--;
                end
            end
        endcase
        r.is_empty = (shadow_cnt == 0);
        r.count    = CNT_WIDTH'(shadow_cnt);
        return r;
    endfunction

    // results first, then the request taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_res.status     = status_t'(status);
            got_res.handle_out = handle_out;
            got_res.is_empty   = is_empty;
            got_res.count      = count;
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: status %0d handle_out %h",
                       status, handle_out);
                err_cnt++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status)
                begin
                    $error("status mismatch: expected %0d actual %0d",
                           want_res.status, got_res.status);
                    err_cnt++;
                end
                if (got_res.handle_out !== want_res.handle_out)
                begin
                    $error("handle_out mismatch: expected %h actual %h",
                           want_res.handle_out, got_res.handle_out);
                    err_cnt++;
                end
                if (got_res.is_empty !== want_res.is_empty)
                begin
                    $error("is_empty mismatch: expected %0d actual %0d",
                           want_res.is_empty, got_res.is_empty);
                    err_cnt++;
                end
                if (got_res.count !== want_res.count)
                begin
                    $error("count mismatch: expected %0d actual %0d",
                           want_res.count, got_res.count);
                    err_cnt++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            shadow_res = apply_queue_op(op_t'(opcode), handle, key);
            // typed hand-written rows are checked against their own numbers
            pending_results.push_back(cur_typed ? cur_res : shadow_res);
        end
    end

    // hand-written table row
    task automatic add_row(op_t op, logic [HANDLE_WIDTH-1:0] h,
                           logic signed [KEY_WIDTH-1:0] k, bit typed,
                           status_t st, logic [HANDLE_WIDTH-1:0] hout,
                           logic em, int cnt);
        request_t r;
        r.op             = op;
        r.h              = h;
        r.k              = k;
        r.typed          = typed;
        r.res.status     = st;
        r.res.handle_out = hout;
        r.res.is_empty   = em;
        r.res.count      = CNT_WIDTH'(cnt);
        directed_rows.push_back(r);
    endtask

    // present one request from a falling edge, return on the falling edge after it
    // was taken; start stays high so the next request can follow back to back
    task automatic send_request(request_t r, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        opcode    = r.op;
        handle    = r.h;
        key       = r.k;
        cur_typed = r.typed;
        cur_res   = r.res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // watchdog
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        request_t r;
        int       idle_pct;
        int       roll;
        int       i;
        bit       filling;

        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_APPEND;
        handle     = '0;
        key        = '0;
        cur_typed  = 1'b0;
        cur_res    = '0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        shadow_cnt = 0;
        filling    = 1'b1;

        // corners on an empty queue, then equal keys and key extremes
        add_row(OP_DEQUEUE,     16'h0000, 32'sd0,        1, ST_MISS, 16'h0000, 1, 0);
        add_row(OP_FIND_REMOVE, 16'h0000, 32'sd0,        1, ST_MISS, 16'h0000, 1, 0);
        add_row(OP_APPEND,      16'hFFFF, 32'h7FFFFFFF,  1, ST_OK,   16'h0000, 0, 1);
        add_row(OP_SORTED,      16'h0000, 32'h80000000,  1, ST_OK,   16'h0000, 0, 2);
        add_row(OP_SORTED,      16'h1234, 32'h7FFFFFFF,  0, ST_OK,   16'h0000, 0, 0);
        add_row(OP_SORTED,      16'h0005, 32'sd0,        0, ST_OK,   16'h0000, 0, 0);
        add_row(OP_FIND_REMOVE, 16'h1234, 32'sd0,        0, ST_OK,   16'h0000, 0, 0);
        add_row(OP_FIND_REMOVE, 16'h4321, 32'sd0,        0, ST_OK,   16'h0000, 0, 0);
        add_row(OP_DEQUEUE,     16'h0000, 32'sd0,        0, ST_OK,   16'h0000, 0, 0);
        // fill up to capacity, with a duplicate handle in the mix
        for (i = 0; i < DEPTH - 2; i++)
            add_row(OP_APPEND, HANDLE_WIDTH'(i % 7), KEY_WIDTH'(i * 3 - 20), 0,
                    ST_OK, 16'h0000, 0, 0);
        // inserts on a full queue are dropped
        add_row(OP_SORTED,      16'hABCD, 32'sd1,        1, ST_FULL, 16'h0000, 0, DEPTH);
        add_row(OP_APPEND,      16'hABCD, 32'sd1,        1, ST_FULL, 16'h0000, 0, DEPTH);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[j])
            send_request(directed_rows[j], 0);

        // random part, a sender idle rate per quarter
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i * 4 / RANDOM_ITEMS)
                0:       idle_pct = 0;
                1:       idle_pct = 78;
                2:       idle_pct = 0;
                default: idle_pct = 12;
            endcase
            // swing between filling and draining so both corners keep coming back
            if (shadow_cnt == DEPTH)
                filling = 1'b0;
            else if (shadow_cnt == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (roll < 10)
                r.op = op_t'($urandom_range(3));
            else if (filling)
                r.op = (roll < 45) ? OP_SORTED : (roll < 70) ? OP_APPEND :
                       (roll < 85) ? OP_DEQUEUE : OP_FIND_REMOVE;
            else
                r.op = (roll < 40) ? OP_DEQUEUE : (roll < 75) ? OP_FIND_REMOVE :
                       (roll < 88) ? OP_SORTED : OP_APPEND;
            // handles: few small ones for duplicates, full range, extremes, held ones
            case ($urandom_range(3))
                0:       r.h = HANDLE_WIDTH'($urandom_range(7));
                1:       r.h = HANDLE_WIDTH'($urandom);
                2:       r.h = $urandom_range(1) ? '1 : '0;
                default: r.h = HANDLE_WIDTH'($urandom);
            endcase
            if (shadow_cnt > 0 && (r.op == OP_FIND_REMOVE ? $urandom_range(99) < 65
                                                          : $urandom_range(99) < 15))
                r.h = shadow_handle[$urandom_range(shadow_cnt - 1)];
            // keys: clustered for ties, full range, extremes, copies of held keys
            case ($urandom_range(4))
                0:       r.k = KEY_WIDTH'($urandom_range(6)) - KEY_WIDTH'(3);
                1:       r.k = KEY_WIDTH'($urandom);
                2:       r.k = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
                3:       r.k = (shadow_cnt > 0) ? shadow_key[$urandom_range(shadow_cnt - 1)]
                                                : KEY_WIDTH'($urandom);
                default: r.k = KEY_WIDTH'($urandom);
            endcase
            r.typed = 1'b0;
            r.res   = '0;
            send_request(r, idle_pct);
        end

        // let the last request finish, then watch for stray strobes
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/srq_pkg.sv
hw/rtl/srq_store.sv
hw/rtl/srq_cmp.sv
hw/rtl/sorted_ready_queue_core.sv
hw/rtl/srq_checker.sv
tb/tb_sorted_ready_queue_core.sv
